>>> design/tqs_pkg.sv
// Package for the tone queue sequencer: field widths, action codes,
// register map and the period adjustment shared by the block and its channel interfaces.
// No dependencies.
`default_nettype none

package tqs_pkg;

   localparam int ACTION_W = 3;
   localparam int PERIOD_W = 16;
   localparam int LENGTH_W = 16;
   localparam int SLEN_W = 8;
   localparam int PEND_W = 5;
   localparam int REPEAT_W = 16;

   localparam int MUSIC_DEPTH_DEF = 32;
   localparam int SOUND_DEPTH_DEF = 32;

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [PERIOD_W-1:0] period_type;
   typedef logic [LENGTH_W-1:0] length_type;

   localparam action_type ACT_TICK = 3'd0;
   localparam action_type ACT_PUSH = 3'd1;
   localparam action_type ACT_CLEAR = 3'd2;
   localparam action_type ACT_ENTRY = 3'd3;
   localparam action_type ACT_STOP = 3'd4;

   localparam period_type SILENT_PERIOD = 16'hFFFF;

   // register file: one 32-bit register per word
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_GRAPHIC_MODE = 1'd0;

   // Scale by 15/16 in graphic mode, then store minus one (a rest becomes silent).
   function automatic period_type adjust_period(input period_type p, input logic graphic);
      logic [PERIOD_W:0] biased;
      period_type scaled;
      biased = {1'b0, p} + (PERIOD_W+1)'(7);
      scaled = graphic ? p - PERIOD_W'(biased >> 4) : p;
      return scaled - 1'b1;
   endfunction

endpackage

`default_nettype wire

>>> design/tqs_if.sv
// Handshake channels of the tone queue sequencer: command transactions in,
// status transactions out. Depends on tqs_pkg.
`default_nettype none

interface tqs_req_if import tqs_pkg::*; ();
   logic       valid;
   logic       ready;
   action_type action;
   period_type period;
   length_type length;

   modport source (output valid, output action, output period, output length, input ready);
   modport sink (input valid, input action, input period, input length, output ready);
endinterface

interface tqs_rsp_if import tqs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              tone_enable;
   period_type        tone_period;
   logic [PEND_W-1:0] music_pending;
   logic              sound_busy;
   logic              overflow;

   modport source (output valid, output tone_enable, output tone_period,
                   output music_pending, output sound_busy, output overflow, input ready);
   modport sink (input valid, input tone_enable, input tone_period,
                 input music_pending, input sound_busy, input overflow, output ready);
endinterface

`default_nettype wire

>>> design/tone_queue_sequencer.sv
// Tone queue sequencer top level: music ring, sound-effect list and tone timer state.
// Depends on tqs_pkg and the channel interfaces in tqs_if.sv.
//
//   channel   | direction | handshake          | payload
//   ----------+-----------+--------------------+--------------------------------------------
//   req_chan  | in        | valid / ready      | action, period, length
//   rsp_chan  | out       | valid / ready      | tone_enable, tone_period, music_pending,
//             |           |                    | sound_busy, overflow
//   APB       | in        | psel/penable/pready| graphic_mode at byte address 0
//
// One transaction per clock sustained while rsp_chan is ready; input register, then status register.
// Every command is at most one write and one read per store plus counter updates.
// Store reads use the next-state head pointers, so the entry under each head is already
// registered when the following command arrives; same-cycle writes are forwarded.
// Synchronous reset clears pointers, counters and the tone; the stores need no clearing pass.
// A stalled status transaction holds all state; the input register still takes one more command.
`default_nettype none

module tone_queue_sequencer import tqs_pkg::*; #(
   parameter int MUSIC_DEPTH = MUSIC_DEPTH_DEF,
   parameter int SOUND_DEPTH = SOUND_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   tqs_req_if.sink                    req_chan,
   tqs_rsp_if.source                  rsp_chan,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   localparam int MIW = $clog2(MUSIC_DEPTH);
   localparam int SIW = $clog2(SOUND_DEPTH);
   localparam int SW = $clog2(SOUND_DEPTH + 1);
   localparam logic [MIW-1:0] MUSIC_LAST = MIW'(MUSIC_DEPTH - 1);
   localparam logic [SIW-1:0] SOUND_LAST = SIW'(SOUND_DEPTH - 1);
   localparam logic [SW-1:0] SOUND_FULL = SW'(SOUND_DEPTH);

   function automatic logic [MIW-1:0] music_inc(input logic [MIW-1:0] v);
      return (v == MUSIC_LAST) ? '0 : v + 1'b1;
   endfunction

   // ---------------------------------------------------------------- register port
   logic                 graphic_mode_ff;
   logic                 graphic_mode_in;
   logic [CSR_IDX_W-1:0] csr_index;

   assign csr_index = paddr[CSR_ADDR_W-1:2];
   assign pready = 1'b1;
   assign prdata = (csr_index == REG_GRAPHIC_MODE) ? {(CSR_DATA_W-1)'(0), graphic_mode_ff} : '0;
   assign graphic_mode_in = (psel && penable && pwrite && csr_index == REG_GRAPHIC_MODE)
                            ? pwdata[0] : graphic_mode_ff;

   // ---------------------------------------------------------------- pipeline control
   logic       in_valid_ff;
   action_type in_action_ff;
   period_type in_period_ff;
   length_type in_length_ff;
   logic       out_valid_ff;
   logic       out_ovf_ff;
   logic       advance;

   // move the held command into the status register when that register is empty or being taken
   assign advance = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   // ---------------------------------------------------------------- state
   logic [MIW-1:0]      music_head_ff, music_head_in;
   logic [MIW-1:0]      music_tail_ff, music_tail_in;
   logic [LENGTH_W-1:0] music_wait_ff, music_wait_in;
   logic [SW-1:0]       sound_head_ff, sound_head_in;
   logic [SW-1:0]       sound_end_ff, sound_end_in;
   logic [SW-1:0]       sound_fill_ff, sound_fill_in;
   logic [SLEN_W-1:0]   sound_wait_ff, sound_wait_in;
   logic [REPEAT_W-1:0] repeat_left_ff, repeat_left_in;
   logic                tone_on_ff, tone_on_in;
   period_type          tone_value_ff, tone_value_in;
   logic                ovf_in;

   // registered store entries under and after the heads, plus a copy of sound entry 0's length
   period_type        mp_cur_ff;
   length_type        ml_next_ff;
   period_type        sp_cur_ff;
   logic [SLEN_W-1:0] sl_next_ff;
   logic [SLEN_W-1:0] sl0_ff;

   logic              music_busy;
   logic              sound_busy;
   logic              music_full;
   logic [SW-1:0]     snd_next;
   period_type        adj_period;
   logic              music_we;
   logic              sound_we;

   assign music_busy = music_head_ff != music_tail_ff;
   assign sound_busy = sound_head_ff != sound_end_ff;
   assign music_full = music_inc(music_tail_ff) == music_head_ff;
   assign snd_next = sound_head_ff + 1'b1;
   assign adj_period = adjust_period(in_period_ff, graphic_mode_ff);

   always_comb begin
      music_head_in = music_head_ff;
      music_tail_in = music_tail_ff;
      music_wait_in = music_wait_ff;
      sound_head_in = sound_head_ff;
      sound_end_in = sound_end_ff;
      sound_fill_in = sound_fill_ff;
      sound_wait_in = sound_wait_ff;
      repeat_left_in = repeat_left_ff;
      tone_on_in = tone_on_ff;
      tone_value_in = tone_value_ff;
      ovf_in = 1'b0;
      music_we = 1'b0;
      sound_we = 1'b0;
      if (advance) begin
         case (in_action_ff)
            ACT_TICK: begin
               if (sound_busy) begin
                  // sound owns the tone; a silent period switches it off
                  if (sp_cur_ff != SILENT_PERIOD) begin
                     tone_on_in = 1'b1;
                     tone_value_in = sp_cur_ff;
                  end else begin
                     tone_on_in = 1'b0;
                  end
                  if (sound_wait_ff <= SLEN_W'(1)) begin
                     if (snd_next == sound_end_ff || snd_next >= SOUND_FULL) begin
                        sound_head_in = '0;
                        if (repeat_left_ff > REPEAT_W'(1)) begin
                           repeat_left_in = repeat_left_ff - 1'b1;
                           sound_wait_in = sl0_ff;
                        end else begin
                           sound_end_in = '0;
                           repeat_left_in = '0;
                           sound_wait_in = '0;
                        end
                     end else begin
                        sound_head_in = snd_next;
                        sound_wait_in = sl_next_ff;
                     end
                  end else begin
                     sound_wait_in = sound_wait_ff - 1'b1;
                  end
               end else if (music_busy) begin
                  if (mp_cur_ff != SILENT_PERIOD) begin
                     tone_on_in = 1'b1;
                     tone_value_in = mp_cur_ff;
                  end else begin
                     tone_on_in = 1'b0;
                  end
               end else begin
                  tone_on_in = 1'b0;
               end
               // music advances on every tick, heard or not
               if (music_busy) begin
                  if (music_wait_ff <= LENGTH_W'(1)) begin
                     music_head_in = music_inc(music_head_ff);
                     music_wait_in = (music_head_in == music_tail_ff) ? '0 : ml_next_ff;
                  end else begin
                     music_wait_in = music_wait_ff - 1'b1;
                  end
               end
            end
            ACT_PUSH: begin
               if (music_full) begin
                  ovf_in = 1'b1;
               end else begin
                  if (!music_busy) begin
                     music_wait_in = in_length_ff;
                  end
                  music_we = 1'b1;
                  music_tail_in = music_inc(music_tail_ff);
               end
            end
            ACT_CLEAR: begin
               sound_head_in = '0;
               sound_end_in = '0;
               sound_fill_in = '0;
               sound_wait_in = '0;
               repeat_left_in = '0;
            end
            ACT_ENTRY: begin
               if (in_length_ff != '0) begin
                  if (sound_fill_ff >= SOUND_FULL) begin
                     ovf_in = 1'b1;
                  end else begin
                     sound_we = 1'b1;
                     sound_fill_in = sound_fill_ff + 1'b1;
                  end
               end else begin
                  // commit: replay the filled list, period is the repeat count
                  sound_end_in = sound_fill_ff;
                  sound_head_in = '0;
                  repeat_left_in = in_period_ff;
                  sound_wait_in = (sound_fill_ff != '0) ? sl0_ff : '0;
               end
            end
            ACT_STOP: begin
               music_head_in = '0;
               music_tail_in = '0;
               music_wait_in = '0;
               sound_head_in = '0;
               sound_end_in = '0;
               sound_fill_in = '0;
               sound_wait_in = '0;
               repeat_left_in = '0;
               tone_on_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- stores
   period_type        music_period_mem [MUSIC_DEPTH];
   length_type        music_length_mem [MUSIC_DEPTH];
   period_type        sound_period_mem [SOUND_DEPTH];
   logic [SLEN_W-1:0] sound_length_mem [SOUND_DEPTH];

   logic [MIW-1:0] music_rd_cur;
   logic [MIW-1:0] music_rd_next;
   logic [SIW-1:0] sound_rd_cur;
   logic [SIW-1:0] sound_rd_next;
   logic [SIW-1:0] sound_wr_addr;

   assign music_rd_cur = music_head_in;
   assign music_rd_next = music_inc(music_head_in);
   assign sound_rd_cur = sound_head_in[SIW-1:0];
   assign sound_rd_next = (sound_rd_cur == SOUND_LAST) ? '0 : sound_rd_cur + 1'b1;
   assign sound_wr_addr = sound_fill_ff[SIW-1:0];

   always_ff @(posedge clock) begin
      if (music_we) begin
         music_period_mem[music_tail_ff] <= adj_period;
         music_length_mem[music_tail_ff] <= in_length_ff;
      end
      if (sound_we) begin
         sound_period_mem[sound_wr_addr] <= adj_period;
         sound_length_mem[sound_wr_addr] <= in_length_ff[SLEN_W-1:0];
      end
   end

   // read at the next-state pointers; forward a write to the same entry
   always_ff @(posedge clock) begin
      mp_cur_ff <= (music_we && music_tail_ff == music_rd_cur)
                   ? adj_period : music_period_mem[music_rd_cur];
      ml_next_ff <= (music_we && music_tail_ff == music_rd_next)
                    ? in_length_ff : music_length_mem[music_rd_next];
      sp_cur_ff <= (sound_we && sound_wr_addr == sound_rd_cur)
                   ? adj_period : sound_period_mem[sound_rd_cur];
      sl_next_ff <= (sound_we && sound_wr_addr == sound_rd_next)
                    ? in_length_ff[SLEN_W-1:0] : sound_length_mem[sound_rd_next];
      if (sound_we && sound_fill_ff == '0) begin
         sl0_ff <= in_length_ff[SLEN_W-1:0];
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         graphic_mode_ff <= 1'b0;
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         out_ovf_ff <= 1'b0;
         music_head_ff <= '0;
         music_tail_ff <= '0;
         music_wait_ff <= '0;
         sound_head_ff <= '0;
         sound_end_ff <= '0;
         sound_fill_ff <= '0;
         sound_wait_ff <= '0;
         repeat_left_ff <= '0;
         tone_on_ff <= 1'b0;
         tone_value_ff <= '0;
      end else begin
         graphic_mode_ff <= graphic_mode_in;
         if (req_chan.valid && req_chan.ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            out_ovf_ff <= ovf_in;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
         music_head_ff <= music_head_in;
         music_tail_ff <= music_tail_in;
         music_wait_ff <= music_wait_in;
         sound_head_ff <= sound_head_in;
         sound_end_ff <= sound_end_in;
         sound_fill_ff <= sound_fill_in;
         sound_wait_ff <= sound_wait_in;
         repeat_left_ff <= repeat_left_in;
         tone_on_ff <= tone_on_in;
         tone_value_ff <= tone_value_in;
      end
   end

   // hold the command payload until it moves on
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_action_ff <= req_chan.action;
         in_period_ff <= req_chan.period;
         in_length_ff <= req_chan.length;
      end
   end

   // ---------------------------------------------------------------- status transaction
   logic [MIW:0]   pend_full;
   logic [MIW+5:0] pend_wide;

   assign pend_full = (music_tail_ff >= music_head_ff)
                      ? {1'b0, music_tail_ff} - {1'b0, music_head_ff}
                      : {1'b0, music_tail_ff} + (MIW+1)'(MUSIC_DEPTH) - {1'b0, music_head_ff};
   assign pend_wide = {5'b0, pend_full};

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.tone_enable = tone_on_ff;
   assign rsp_chan.tone_period = tone_value_ff;
   assign rsp_chan.music_pending = pend_wide[PEND_W-1:0];
   assign rsp_chan.sound_busy = sound_busy;
   assign rsp_chan.overflow = out_ovf_ff;

   // ---------------------------------------------------------------- checks
   a_sound_order: assert property (@(posedge clock) disable iff (reset)
      sound_busy |-> (sound_head_ff < sound_end_ff && sound_end_ff <= sound_fill_ff))
      else $error("sound pointers out of order");

   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && in_action_ff == ACT_STOP) |=>
         (music_head_ff == '0 && music_tail_ff == '0 && !tone_on_ff && !sound_busy))
      else $error("stop left queue or tone active");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (advance && in_action_ff == ACT_PUSH && music_full) |=>
         (out_ovf_ff && music_tail_ff == $past(music_tail_ff)))
      else $error("push into full ring was not dropped");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(music_head_ff) && $stable(sound_head_ff) && $stable(tone_value_ff)))
      else $error("state moved without a command");

endmodule

`default_nettype wire
